// ===== src/si_pkg.sv =====
package si_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = 17;
    localparam int PROD_W  = 34;
    localparam int SUM_W   = 35;
    localparam int MAG_W   = 33;
    localparam int ABS_W   = 16;
    localparam int XY_W    = 24;
    localparam int DIST_W  = 25;

    localparam int XY_MAX   = 8388607;
    localparam int XY_MIN   = -8388608;
    localparam int DIST_MAX = 33554431;

    typedef struct packed {
        logic signed [COORD_W-1:0] seg1_start_x;
        logic signed [COORD_W-1:0] seg1_start_y;
        logic signed [COORD_W-1:0] seg1_end_x;
        logic signed [COORD_W-1:0] seg1_end_y;
        logic signed [COORD_W-1:0] seg2_start_x;
        logic signed [COORD_W-1:0] seg2_start_y;
        logic signed [COORD_W-1:0] seg2_end_x;
        logic signed [COORD_W-1:0] seg2_end_y;
    } t_in_item;

    typedef struct packed {
        logic                     hit;
        logic signed [XY_W-1:0]   cross_x;
        logic signed [XY_W-1:0]   cross_y;
        logic        [DIST_W-1:0] travel_distance;
    } t_out_item;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] s1x;
        logic signed [COORD_W-1:0] s1y;
        logic                      neg_x;
        logic                      neg_y;
        logic        [ABS_W-1:0]   ax;
        logic        [ABS_W-1:0]   ay;
        logic        [MAG_W-1:0]   rt;
        logic        [MAG_W-1:0]   dn;
    } t_geo;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] s1x;
        logic signed [COORD_W-1:0] s1y;
        logic                      neg_x;
        logic                      neg_y;
    } t_place;

    function automatic logic [MAG_W-1:0] mag_sum(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = v[SUM_W-1] ? -v : v;
        return t[MAG_W-1:0];
    endfunction

    function automatic logic [ABS_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-1:0] t;
        t = v[DIFF_W-1] ? -v : v;
        return t[ABS_W-1:0];
    endfunction

endpackage

// ===== src/si_front.sv =====
module si_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  si_pkg::t_in_item  i_item,
    output logic              o_valid,
    output si_pkg::t_geo      o_geo,
    output logic [si_pkg::MAG_W-1:0] o_len2
);

    logic                             r_a_vld;
    logic signed [si_pkg::DIFF_W-1:0] r_d1x, r_d1y, r_d2x, r_d2y, r_ox, r_oy;
    logic signed [si_pkg::COORD_W-1:0] r_a_s1x, r_a_s1y;

    logic                             r_b_vld;
    logic signed [si_pkg::PROD_W-1:0] r_pd1, r_pd2, r_pr1, r_pr2, r_ps1, r_ps2, r_plx, r_ply;
    logic signed [si_pkg::DIFF_W-1:0] r_b_d1x, r_b_d1y;
    logic signed [si_pkg::COORD_W-1:0] r_b_s1x, r_b_s1y;

    logic                             r_c_vld;
    logic signed [si_pkg::SUM_W-1:0]  r_den, r_rtop, r_stop;
    logic        [si_pkg::MAG_W-1:0]  r_c_len2;
    logic        [si_pkg::ABS_W-1:0]  r_c_ax, r_c_ay;
    logic                             r_c_negx, r_c_negy;
    logic signed [si_pkg::COORD_W-1:0] r_c_s1x, r_c_s1y;

    logic                             r_d_vld;
    si_pkg::t_geo                     r_geo;
    logic        [si_pkg::MAG_W-1:0]  r_len2;

    logic signed [si_pkg::SUM_W-1:0]  n_len2;
    logic        [si_pkg::MAG_W-1:0]  n_md, n_mr, n_ms;
    logic                             n_hit;

    always_comb begin
        n_len2 = si_pkg::SUM_W'(r_plx) + si_pkg::SUM_W'(r_ply);
        n_md = si_pkg::mag_sum(r_den);
        n_mr = si_pkg::mag_sum(r_rtop);
        n_ms = si_pkg::mag_sum(r_stop);
        n_hit = (r_den != '0) && (r_rtop != '0) && (r_stop != '0)
            && (r_rtop[si_pkg::SUM_W-1] == r_den[si_pkg::SUM_W-1])
            && (r_stop[si_pkg::SUM_W-1] == r_den[si_pkg::SUM_W-1])
            && (n_mr < n_md) && (n_ms < n_md);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1x   <= si_pkg::DIFF_W'(i_item.seg1_end_x) - si_pkg::DIFF_W'(i_item.seg1_start_x);
            r_d1y   <= si_pkg::DIFF_W'(i_item.seg1_end_y) - si_pkg::DIFF_W'(i_item.seg1_start_y);
            r_d2x   <= si_pkg::DIFF_W'(i_item.seg2_end_x) - si_pkg::DIFF_W'(i_item.seg2_start_x);
            r_d2y   <= si_pkg::DIFF_W'(i_item.seg2_end_y) - si_pkg::DIFF_W'(i_item.seg2_start_y);
            r_ox    <= si_pkg::DIFF_W'(i_item.seg1_start_x) - si_pkg::DIFF_W'(i_item.seg2_start_x);
            r_oy    <= si_pkg::DIFF_W'(i_item.seg1_start_y) - si_pkg::DIFF_W'(i_item.seg2_start_y);
            r_a_s1x <= i_item.seg1_start_x;
            r_a_s1y <= i_item.seg1_start_y;

            r_pd1   <= r_d1x * r_d2y;
            r_pd2   <= r_d1y * r_d2x;
            r_pr1   <= r_oy * r_d2x;
            r_pr2   <= r_ox * r_d2y;
            r_ps1   <= r_oy * r_d1x;
            r_ps2   <= r_ox * r_d1y;
            r_plx   <= r_d1x * r_d1x;
            r_ply   <= r_d1y * r_d1y;
            r_b_d1x <= r_d1x;
            r_b_d1y <= r_d1y;
            r_b_s1x <= r_a_s1x;
            r_b_s1y <= r_a_s1y;

            r_den    <= si_pkg::SUM_W'(r_pd1) - si_pkg::SUM_W'(r_pd2);
            r_rtop   <= si_pkg::SUM_W'(r_pr1) - si_pkg::SUM_W'(r_pr2);
            r_stop   <= si_pkg::SUM_W'(r_ps1) - si_pkg::SUM_W'(r_ps2);
            r_c_len2 <= n_len2[si_pkg::MAG_W-1:0];
            r_c_ax   <= si_pkg::mag_diff(r_b_d1x);
            r_c_ay   <= si_pkg::mag_diff(r_b_d1y);
            r_c_negx <= r_b_d1x[si_pkg::DIFF_W-1];
            r_c_negy <= r_b_d1y[si_pkg::DIFF_W-1];
            r_c_s1x  <= r_b_s1x;
            r_c_s1y  <= r_b_s1y;

            r_geo.hit   <= n_hit;
            r_geo.s1x   <= r_c_s1x;
            r_geo.s1y   <= r_c_s1y;
            r_geo.neg_x <= r_c_negx;
            r_geo.neg_y <= r_c_negy;
            r_geo.ax    <= r_c_ax;
            r_geo.ay    <= r_c_ay;
            r_geo.rt    <= n_mr;
            r_geo.dn    <= n_md;
            r_len2      <= r_c_len2;
        end
    end

    assign o_valid = r_d_vld;
    assign o_geo   = r_geo;
    assign o_len2  = r_len2;

endmodule

// ===== src/si_sqrt.sv =====
module si_sqrt #(
    parameter int FRAC_BITS = 8,
    parameter int PW = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [si_pkg::MAG_W-1:0] i_value,
    input  logic [PW-1:0]           i_pay,
    output logic                    o_valid,
    output logic [16+FRAC_BITS:0]   o_root,
    output logic [PW-1:0]           o_pay
);

    localparam int RW = 17 + FRAC_BITS;
    localparam int VW = 2 * RW;
    localparam int MW = RW + 2;

    logic [VW-1:0] r_v    [0:RW];
    logic [MW-1:0] r_rem  [0:RW];
    logic [RW-1:0] r_root [0:RW];
    logic [PW-1:0] r_pay  [0:RW];
    logic          r_vld  [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0]    <= {(VW - si_pkg::MAG_W - 2*FRAC_BITS)'(0), i_value,
                          (2*FRAC_BITS)'(0)};
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_pay[0]  <= i_pay;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_step
        localparam int I = RW - 1 - k;
        logic [MW-1:0] n_rs, n_trial;
        logic          n_ge;

        always_comb begin
            n_rs    = {r_rem[k][MW-3:0], r_v[k][2*I+1:2*I]};
            n_trial = {r_root[k], 2'b01};
            n_ge    = n_rs >= n_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k+1]    <= r_v[k];
                r_rem[k+1]  <= n_ge ? n_rs - n_trial : n_rs;
                r_root[k+1] <= {r_root[k][RW-2:0], n_ge};
                r_pay[k+1]  <= r_pay[k];
            end
        end
    end

    assign o_valid = r_vld[RW];
    assign o_root  = r_root[RW];
    assign o_pay   = r_pay[RW];

endmodule

// ===== src/si_divider.sv =====
module si_divider #(
    parameter int NW = 59,
    parameter int QW = 26,
    parameter int LANES = 3,
    parameter int PW = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [LANES-1:0][NW-1:0]    i_num,
    input  logic [si_pkg::MAG_W-1:0]    i_den,
    input  logic [PW-1:0]               i_pay,
    output logic                        o_valid,
    output logic [LANES-1:0][QW-1:0]    o_quot,
    output logic [PW-1:0]               o_pay
);

    localparam int DW = si_pkg::MAG_W;

    logic [LANES-1:0][NW-1:0] r_num  [0:QW];
    logic [LANES-1:0][DW-1:0] r_rem  [0:QW];
    logic [LANES-1:0][QW-1:0] r_quot [0:QW];
    logic [DW-1:0]            r_den  [0:QW];
    logic [PW-1:0]            r_pay  [0:QW];
    logic                     r_vld  [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= i_num;
            for (int l = 0; l < LANES; l++) begin
                r_rem[0][l] <= i_num[l][QW+DW-1:QW];
            end
            r_quot[0] <= '0;
            r_den[0]  <= i_den;
            r_pay[0]  <= i_pay;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int I = QW - 1 - k;
        logic [LANES-1:0][DW-1:0] n_rem;
        logic [LANES-1:0]         n_ge;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                logic [DW:0] rs;
                rs = {r_rem[k][l], r_num[k][l][I]};
                n_ge[l] = rs >= {1'b0, r_den[k]};
                n_rem[l] = n_ge[l] ? DW'(rs - {1'b0, r_den[k]}) : rs[DW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k+1] <= r_num[k];
                r_rem[k+1] <= n_rem;
                for (int l = 0; l < LANES; l++) begin
                    r_quot[k+1][l] <= {r_quot[k][l][QW-2:0], n_ge[l]};
                end
                r_den[k+1] <= r_den[k];
                r_pay[k+1] <= r_pay[k];
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quot  = r_quot[QW];
    assign o_pay   = r_pay[QW];

endmodule

// ===== src/segment_intersection.sv =====
// Channel   Valid         Ready         Payload
// input     i_in_valid    o_in_ready    i_in_item  (si_pkg::t_in_item)
// output    o_out_valid   i_out_ready   o_out_item (si_pkg::t_out_item)
//
// One item enters per cycle unless the output register stalls; the pipeline
// holds the bit-per-stage square root (17 + FRAC_BITS stages), the bit-per-stage
// divider (18 + FRAC_BITS stages) and the front, multiply and output stages.
// Reset is synchronous and clears all valid bits.
// A stalled output register holds every stage; nothing is dropped or repeated.
module segment_intersection #(
    parameter int FRAC_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  si_pkg::t_in_item  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output si_pkg::t_out_item o_out_item
);

    localparam int RW   = 17 + FRAC_BITS;
    localparam int QW   = 18 + FRAC_BITS;
    localparam int NW   = 51 + FRAC_BITS;
    localparam int PWID = 20 + FRAC_BITS;
    localparam int CW   = (QW > si_pkg::DIST_W) ? QW : si_pkg::DIST_W;
    localparam int GW   = $bits(si_pkg::t_geo);
    localparam int LW   = $bits(si_pkg::t_place);

    localparam logic signed [PWID-1:0] LIM_HI = PWID'(si_pkg::XY_MAX);
    localparam logic signed [PWID-1:0] LIM_LO = PWID'(si_pkg::XY_MIN);
    localparam logic [CW-1:0]          LIM_D  = CW'(si_pkg::DIST_MAX);

    logic                           en;
    logic                           f_valid, q_valid, d_valid;
    si_pkg::t_geo                   f_geo, q_geo;
    logic [si_pkg::MAG_W-1:0]       f_len2;
    logic [RW-1:0]                  q_root;
    logic [GW-1:0]                  q_pay;
    logic [2:0][NW-1:0]             num;
    logic [2:0][QW-1:0]             quot;
    logic [LW-1:0]                  d_pay;
    si_pkg::t_place                 pl, pl_in;
    logic [RW+si_pkg::MAG_W-1:0]    prod_d;
    logic [si_pkg::ABS_W+si_pkg::MAG_W-1:0] prod_x, prod_y;

    logic [QW:0]                    rnd_x, rnd_y, rnd_d;
    logic signed [PWID-1:0]         base_x, base_y, v_x, v_y;
    logic [CW-1:0]                  dist_c;

    logic                           r_out_vld;
    si_pkg::t_out_item              r_out, n_out;

    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    si_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_valid (f_valid),
        .o_geo   (f_geo),
        .o_len2  (f_len2)
    );

    si_sqrt #(
        .FRAC_BITS (FRAC_BITS),
        .PW        (GW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_value (f_len2),
        .i_pay   (f_geo),
        .o_valid (q_valid),
        .o_root  (q_root),
        .o_pay   (q_pay)
    );

    always_comb begin
        q_geo  = si_pkg::t_geo'(q_pay);
        prod_x = q_geo.ax * q_geo.rt;
        prod_y = q_geo.ay * q_geo.rt;
        prod_d = q_root * q_geo.rt;
        num[0] = NW'(prod_x) << (FRAC_BITS + 1);
        num[1] = NW'(prod_y) << (FRAC_BITS + 1);
        num[2] = NW'(prod_d) << 1;
        pl_in.hit   = q_geo.hit;
        pl_in.s1x   = q_geo.s1x;
        pl_in.s1y   = q_geo.s1y;
        pl_in.neg_x = q_geo.neg_x;
        pl_in.neg_y = q_geo.neg_y;
    end

    si_divider #(
        .NW    (NW),
        .QW    (QW),
        .LANES (3),
        .PW    (LW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_valid),
        .i_num   (num),
        .i_den   (q_geo.dn),
        .i_pay   (pl_in),
        .o_valid (d_valid),
        .o_quot  (quot),
        .o_pay   (d_pay)
    );

    always_comb begin
        pl     = si_pkg::t_place'(d_pay);
        rnd_x  = ((QW+1)'(quot[0]) + (QW+1)'(1)) >> 1;
        rnd_y  = ((QW+1)'(quot[1]) + (QW+1)'(1)) >> 1;
        rnd_d  = ((QW+1)'(quot[2]) + (QW+1)'(1)) >> 1;
        base_x = PWID'(pl.s1x) <<< FRAC_BITS;
        base_y = PWID'(pl.s1y) <<< FRAC_BITS;
        v_x    = pl.neg_x ? base_x - $signed(PWID'(rnd_x)) : base_x + $signed(PWID'(rnd_x));
        v_y    = pl.neg_y ? base_y - $signed(PWID'(rnd_y)) : base_y + $signed(PWID'(rnd_y));
        dist_c = CW'(rnd_d);

        n_out = '0;
        if (pl.hit) begin
            n_out.hit = 1'b1;
            n_out.cross_x = (v_x > LIM_HI) ? si_pkg::XY_W'(si_pkg::XY_MAX) :
                            (v_x < LIM_LO) ? si_pkg::XY_W'(si_pkg::XY_MIN) :
                            v_x[si_pkg::XY_W-1:0];
            n_out.cross_y = (v_y > LIM_HI) ? si_pkg::XY_W'(si_pkg::XY_MAX) :
                            (v_y < LIM_LO) ? si_pkg::XY_W'(si_pkg::XY_MIN) :
                            v_y[si_pkg::XY_W-1:0];
            n_out.travel_distance = (dist_c > LIM_D) ? LIM_D[si_pkg::DIST_W-1:0] :
                                    dist_c[si_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

// ===== src/si_checker.sv =====
module si_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input si_pkg::t_out_item o_out_item
);

    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("Input ready does not follow the output stage.");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.hit) |-> (o_out_item.cross_x == '0
            && o_out_item.cross_y == '0 && o_out_item.travel_distance == '0))
        else $error("A missed item carries a nonzero point or distance.");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("A stalled output item changed or vanished.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid after reset.");

endmodule

bind segment_intersection si_checker u_si_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== bench/segment_checker.sv =====
`timescale 1ns / 1ps

module segment_checker #(
    parameter int FRAC_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  si_pkg::t_in_item  i_in_item,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  si_pkg::t_out_item i_out_item,
    output int                o_fail_count,
    output int                o_pending
);
    import si_pkg::*;

    t_out_item crossing_queue[$];
    int        fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = crossing_queue.size();

    function automatic longint unsigned mag(input longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic bit strictly_inside(input longint top, input longint den);
        if (top == 0) return 0;
        if ((top < 0) != (den < 0)) return 0;
        return mag(top) < mag(den);
    endfunction

    function automatic longint unsigned scaled_round(input longint unsigned a,
                                                     input longint unsigned b,
                                                     input longint unsigned den);
        logic [127:0] q;
        q = ({64'd0, a} * {64'd0, b} * 128'd2) / {64'd0, den};
        return longint'((q + 128'd1) >> 1);
    endfunction

    function automatic longint unsigned length_fixed(input longint unsigned len2);
        logic [127:0] x;
        logic [127:0] root;
        logic [127:0] cand;
        x = {64'd0, len2} << (2 * FRAC_BITS);
        root = 0;
        for (int i = 40; i >= 0; i--) begin
            cand = root | (128'd1 << i);
            if (cand * cand <= x) root = cand;
        end
        return longint'(root);
    endfunction

    function automatic logic [XY_W-1:0] place_axis(input longint start, input longint d,
                                                   input longint unsigned rt,
                                                   input longint unsigned dn);
        longint m;
        longint v;
        m = scaled_round(mag(d) << FRAC_BITS, rt, dn);
        v = start * (longint'(1) << FRAC_BITS);
        v = d < 0 ? v - m : v + m;
        if (v > XY_MAX) v = XY_MAX;
        if (v < XY_MIN) v = XY_MIN;
        return v[XY_W-1:0];
    endfunction

    function automatic t_out_item predict_crossing(input t_in_item it);
        t_out_item r;
        longint s1x, s1y, d1x, d1y, d2x, d2y, ox, oy, den, rtop, stop;
        longint unsigned rt, dn, dist_q;
        s1x = it.seg1_start_x;
        s1y = it.seg1_start_y;
        d1x = longint'(it.seg1_end_x) - s1x;
        d1y = longint'(it.seg1_end_y) - s1y;
        d2x = longint'(it.seg2_end_x) - longint'(it.seg2_start_x);
        d2y = longint'(it.seg2_end_y) - longint'(it.seg2_start_y);
        ox = s1x - longint'(it.seg2_start_x);
        oy = s1y - longint'(it.seg2_start_y);
        den = d1x * d2y - d1y * d2x;
        rtop = oy * d2x - ox * d2y;
        stop = oy * d1x - ox * d1y;
        r = '0;
        if (den != 0 && strictly_inside(rtop, den) && strictly_inside(stop, den)) begin
            rt = mag(rtop);
            dn = mag(den);
            dist_q = scaled_round(length_fixed(d1x * d1x + d1y * d1y), rt, dn);
            if (dist_q > DIST_MAX) dist_q = DIST_MAX;
            r.hit = 1'b1;
            r.cross_x = place_axis(s1x, d1x, rt, dn);
            r.cross_y = place_axis(s1y, d1y, rt, dn);
            r.travel_distance = dist_q[DIST_W-1:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) crossing_queue.push_back(predict_crossing(i_in_item));
            if (i_out_valid && i_out_ready) begin
                if (crossing_queue.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("Unexpected item: %p", i_out_item);
                end else begin
                    want = crossing_queue.pop_front();
                    if (want.hit !== i_out_item.hit || want.cross_x !== i_out_item.cross_x
                        || want.cross_y !== i_out_item.cross_y
                        || want.travel_distance !== i_out_item.travel_distance) begin
                        fails++;
                        if (fails <= 10)
                            $display("Mismatch: expected %p, got %p", want, i_out_item);
                    end
                end
            end
        end
    end
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import si_pkg::*;

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_in_valid = 0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 0;
    t_out_item o_out_item;
    int        fail_count;
    int        pending;
    bit        burst_mode = 0;

    segment_intersection dut (.*);

    segment_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_item(i_in_item),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_item(o_out_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("** segment_intersection: FAILED **");
        $finish;
    end

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] rnd_coord(input int mode);
        if (mode == 0) return 16'($urandom_range(0, 65535));
        return clamp16($signed($urandom_range(0, 40)) - 20);
    endfunction

    function automatic t_in_item random_pair();
        t_in_item it;
        int mode;
        int mx, my, vx, vy;
        mode = $urandom_range(0, 3) == 0 ? 1 : 0;
        it.seg1_start_x = rnd_coord(mode);
        it.seg1_start_y = rnd_coord(mode);
        it.seg1_end_x = rnd_coord(mode);
        it.seg1_end_y = rnd_coord(mode);
        if ($urandom_range(0, 9) < 6) begin
            // Second segment straddles the midpoint of the first, so most pairs cross.
            mx = (int'(it.seg1_start_x) + int'(it.seg1_end_x)) / 2;
            my = (int'(it.seg1_start_y) + int'(it.seg1_end_y)) / 2;
            vx = int'(rnd_coord(mode)) / int'($urandom_range(1, 4));
            vy = int'(rnd_coord(mode)) / int'($urandom_range(1, 4));
            it.seg2_start_x = clamp16(mx + vx);
            it.seg2_start_y = clamp16(my + vy);
            it.seg2_end_x = clamp16(mx - vx);
            it.seg2_end_y = clamp16(my - vy);
        end else begin
            it.seg2_start_x = rnd_coord(mode);
            it.seg2_start_y = rnd_coord(mode);
            it.seg2_end_x = rnd_coord(mode);
            it.seg2_end_y = rnd_coord(mode);
        end
        return it;
    endfunction

    function automatic t_in_item pair_of(input int a, b, c, d, e, f, g, h);
        return {clamp16(a), clamp16(b), clamp16(c), clamp16(d),
                clamp16(e), clamp16(f), clamp16(g), clamp16(h)};
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    initial begin
        int served;
        int gap;
        served = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = burst_mode ? 0 : $urandom_range(0, 16);
            if (served == 300) gap = 600;
            if (gap > 0) begin
                i_out_ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            served++;
        end
    end

    initial begin
        t_in_item directed[$];
        int lim;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        directed.push_back(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        directed.push_back(pair_of(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
        directed.push_back(pair_of(0, 0, 10, 0, 0, 5, 10, 5));
        directed.push_back(pair_of(0, 0, 10, 0, 2, 0, 8, 0));
        directed.push_back(pair_of(0, 0, 10, 10, 0, 10, 10, 0));
        directed.push_back(pair_of(0, 0, 10, 0, 0, -5, 0, 5));
        directed.push_back(pair_of(0, 0, 10, 0, 10, -5, 10, 5));
        directed.push_back(pair_of(0, 0, 10, 0, 5, 0, 5, 5));
        directed.push_back(pair_of(0, 0, 10, 0, 5, -5, 5, 0));
        directed.push_back(pair_of(3, 3, 3, 3, 0, 0, 6, 6));
        directed.push_back(pair_of(0, 0, 10, 0, 20, -5, 20, 5));
        directed.push_back(pair_of(0, 0, 3, 7, 0, 7, 3, 0));
        directed.push_back(pair_of(-1, -1, 2, 1, 0, 1, 1, -2));
        directed.push_back(pair_of(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
        directed.push_back(pair_of(-32768, 0, 32767, 0, 0, -32768, 1, 32767));
        directed.push_back(pair_of(0, -32768, 0, 32767, -32768, 1, 32767, 0));
        directed.push_back(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(pair_of(-1, -1, -1, -1, -1, -1, -1, -1));
        foreach (directed[k]) send_item(directed[k]);
        for (int n = 0; n < 1700; n++) begin
            if (n % 250 == 0) burst_mode = $urandom_range(0, 2) == 0;
            send_item(random_pair());
        end
        i_in_valid <= 0;
        lim = 0;
        while (pending != 0 && lim < 200000) begin
            @(posedge i_clk);
            lim++;
        end
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** segment_intersection: PASSED **");
        end else begin
            $display("** segment_intersection: FAILED **");
        end
        $finish;
    end
endmodule

// ===== segment_intersection.f =====
src/si_pkg.sv
src/si_front.sv
src/si_sqrt.sv
src/si_divider.sv
src/segment_intersection.sv
src/si_checker.sv
bench/segment_checker.sv
bench/testbench.sv
